// ===== hdl/dbms_pkg.sv =====
package dbms_pkg;

	// supervisor modes
	localparam logic [3:0] M_INIT       = 4'd0;
	localparam logic [3:0] M_IDLE       = 4'd1;
	localparam logic [3:0] M_PRELIM     = 4'd2;
	localparam logic [3:0] M_PREPARE    = 4'd3;
	localparam logic [3:0] M_READY      = 4'd4;
	localparam logic [3:0] M_WORK       = 4'd5;
	localparam logic [3:0] M_PARK       = 4'd6;
	localparam logic [3:0] M_MANUAL     = 4'd7;
	localparam logic [3:0] M_COMPLETE   = 4'd8;
	localparam logic [3:0] M_SHUTDOWN   = 4'd9;
	localparam logic [3:0] M_POWERSAVER = 4'd10;
	localparam logic [3:0] M_TERMINATE  = 4'd11;
	localparam logic [3:0] M_INTERRUPT  = 4'd12;
	localparam logic [3:0] M_COUNT      = 4'd13;

	// dose board states
	localparam logic [3:0] B_IDLE      = 4'd0;
	localparam logic [3:0] B_DUMMY     = 4'd1;
	localparam logic [3:0] B_DUMMY_END = 4'd2;
	localparam logic [3:0] B_PREPARE   = 4'd3;
	localparam logic [3:0] B_READY     = 4'd4;
	localparam logic [3:0] B_RADIATION = 4'd5;
	localparam logic [3:0] B_COMPLETE  = 4'd6;
	localparam logic [3:0] B_FAULT     = 4'd7;

	// command targets
	localparam logic [1:0] TGT_ALIGN = 2'd0;
	localparam logic [1:0] TGT_B1    = 2'd1;
	localparam logic [1:0] TGT_B2    = 2'd2;

	// status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_SAME    = 2'd1;
	localparam logic [1:0] ST_ILLEGAL = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_DUMMY_METER = 3'd0;
	localparam logic [2:0] CFG_PULSE_MODE  = 3'd1;
	localparam logic [2:0] CFG_CAL_MODE    = 3'd2;
	localparam logic [2:0] CFG_CAL_PRF     = 3'd3;
	localparam logic [2:0] CFG_DOSE_METER  = 3'd4;
	localparam logic [2:0] CFG_BEAM_ID     = 3'd5;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [3:0] {
		K_NONE      = 4'd0,
		K_HANDSHAKE = 4'd1,
		K_CLEAR     = 4'd2,
		K_GENMODE   = 4'd3,
		K_PULSE     = 4'd4,
		K_METER     = 4'd5,
		K_PRF       = 4'd6,
		K_BEAM      = 4'd7,
		K_STATE     = 4'd8
	} kind_t;

	// command runs that one item can cause
	typedef enum logic [3:0] {
		RUN_NONE,
		RUN_INIT,
		RUN_PRELIM,
		RUN_PREP,
		RUN_READY,
		RUN_WORK,
		RUN_FAULT,
		RUN_FAULT_B1,
		RUN_FAULT_B2,
		RUN_PREP_STATE
	} run_t;

	typedef struct packed {
		run_t       run;
		logic [1:0] status;
		logic [3:0] mode;
	} desc_t;

	typedef struct packed {
		logic [31:0] dummy_meter;
		logic [7:0]  pulse_cfg;
		logic        cal_mode;
		logic [31:0] cal_prf;
		logic [31:0] cal_meter;
		logic [15:0] beam_id;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  target;
		logic [31:0] value;
		logic        last;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic       clr_pending;
	} gate_t;

	// bit c set: the move from mode c into the given mode is legal
	function automatic logic [15:0] legal_from(input logic [3:0] m);
		logic [15:0] row;
		row = '0;
		unique case (m)
			M_INIT:       row[M_IDLE] = 1'b1;
			M_IDLE: begin
				row[M_INIT] = 1'b1;
				row[M_POWERSAVER] = 1'b1;
				row[M_TERMINATE] = 1'b1;
				row[M_COMPLETE] = 1'b1;
				row[M_MANUAL] = 1'b1;
				row[M_PARK] = 1'b1;
			end
			M_PRELIM:     row[M_IDLE] = 1'b1;
			M_PREPARE: begin
				row[M_PRELIM] = 1'b1;
				row[M_COMPLETE] = 1'b1;
			end
			M_READY: begin
				row[M_PREPARE] = 1'b1;
				row[M_INTERRUPT] = 1'b1;
			end
			M_WORK:       row[M_READY] = 1'b1;
			M_PARK:       row[M_IDLE] = 1'b1;
			M_MANUAL:     row[M_IDLE] = 1'b1;
			M_COMPLETE:   row[M_WORK] = 1'b1;
			M_SHUTDOWN: begin
				row[M_IDLE] = 1'b1;
				row[M_POWERSAVER] = 1'b1;
			end
			M_POWERSAVER: row[M_IDLE] = 1'b1;
			M_TERMINATE: begin
				row[M_PRELIM] = 1'b1;
				row[M_PREPARE] = 1'b1;
				row[M_READY] = 1'b1;
				row[M_WORK] = 1'b1;
				row[M_INTERRUPT] = 1'b1;
			end
			M_INTERRUPT: begin
				row[M_READY] = 1'b1;
				row[M_WORK] = 1'b1;
			end
			default:      row = '0;
		endcase
		return row;
	endfunction

	// legality check shared by remote and local items
	function automatic gate_t gate(input logic [3:0] req, input logic [3:0] mode,
			input logic pending);
		gate_t g;
		logic [15:0] row;
		g.status = ST_DONE;
		g.clr_pending = 1'b0;
		row = legal_from(req);
		if (req >= M_COUNT) begin
			g.status = ST_INVALID;
		end else if (req == mode) begin
			if (pending && req == M_PREPARE) begin
				g.clr_pending = 1'b1;
			end else begin
				g.status = ST_SAME;
			end
		end else if (!row[mode]) begin
			g.status = ST_ILLEGAL;
		end
		return g;
	endfunction

	// command run issued for a remote request
	function automatic run_t remote_run(input logic [3:0] req);
		run_t r;
		unique case (req)
			M_INIT:      r = RUN_INIT;
			M_PRELIM:    r = RUN_PRELIM;
			M_PREPARE:   r = RUN_PREP;
			M_READY:     r = RUN_READY;
			M_WORK:      r = RUN_WORK;
			M_TERMINATE: r = RUN_FAULT;
			M_INTERRUPT: r = RUN_FAULT;
			default:     r = RUN_NONE;
		endcase
		return r;
	endfunction

	// one board command of a run, picked by its step number
	function automatic cmd_t step_cmd(input run_t run, input logic [3:0] idx,
			input cfg_t cfg);
		cmd_t c;
		logic [2:0] pair;
		logic [1:0] tgt;
		pair = idx[3:1];
		tgt = idx[0] ? TGT_B2 : TGT_B1;
		c.kind = K_NONE;
		c.target = TGT_ALIGN;
		c.value = '0;
		c.last = 1'b1;
		unique case (run)
			RUN_NONE: ;
			RUN_INIT: begin
				c.kind = K_HANDSHAKE;
				c.target = idx[1:0];
				c.last = (idx == 4'd2);
			end
			RUN_PRELIM: begin
				c.target = tgt;
				c.last = (idx == 4'd9);
				unique case (pair)
					3'd0: c.kind = K_CLEAR;
					3'd1: c.kind = K_GENMODE;
					3'd2: c.kind = K_PULSE;
					3'd3: begin
						c.kind = K_METER;
						c.value = cfg.dummy_meter;
					end
					default: begin
						c.kind = K_STATE;
						c.value = {28'd0, B_DUMMY};
					end
				endcase
			end
			RUN_PREP: begin
				c.target = tgt;
				c.last = cfg.cal_mode ? (idx == 4'd11) : (idx == 4'd9);
				unique case (pair)
					3'd0: c.kind = K_CLEAR;
					3'd1: begin
						c.kind = K_GENMODE;
						c.value = 32'd1;
					end
					3'd2: begin
						c.kind = K_PULSE;
						c.value = {24'd0, cfg.pulse_cfg};
					end
					3'd3: begin
						if (cfg.cal_mode) begin
							c.kind = K_PRF;
							c.value = cfg.cal_prf;
						end else begin
							c.kind = K_BEAM;
							c.value = {16'd0, cfg.beam_id};
						end
					end
					3'd4: begin
						if (cfg.cal_mode) begin
							c.kind = K_METER;
							c.value = cfg.cal_meter;
						end else begin
							c.kind = K_STATE;
							c.value = {28'd0, B_PREPARE};
						end
					end
					default: begin
						c.kind = K_STATE;
						c.value = {28'd0, B_PREPARE};
					end
				endcase
			end
			RUN_READY: begin
				c.kind = K_STATE;
				c.target = tgt;
				c.value = {28'd0, B_READY};
				c.last = idx[0];
			end
			RUN_WORK: begin
				c.kind = K_STATE;
				c.target = tgt;
				c.value = {28'd0, B_RADIATION};
				c.last = idx[0];
			end
			RUN_FAULT: begin
				c.kind = K_STATE;
				c.target = tgt;
				c.value = {28'd0, B_FAULT};
				c.last = idx[0];
			end
			RUN_FAULT_B1: begin
				c.kind = K_STATE;
				c.target = TGT_B1;
				c.value = {28'd0, B_FAULT};
			end
			RUN_FAULT_B2: begin
				c.kind = K_STATE;
				c.target = TGT_B2;
				c.value = {28'd0, B_FAULT};
			end
			RUN_PREP_STATE: begin
				c.kind = K_STATE;
				c.target = tgt;
				c.value = {28'd0, B_PREPARE};
				c.last = idx[0];
			end
			default: ;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/dbms_front.sv =====
module dbms_front import dbms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       cmd,
	input  logic [3:0] requested_mode,
	input  logic [3:0] board1_state,
	input  logic [3:0] board2_state,
	output desc_t      desc
);

	logic [3:0] mode_q;
	logic       pending_q;
	logic [3:0] mode_n;
	logic       pending_n;
	logic       f1;
	logic       f2;
	logic       do_set;
	logic [3:0] tgt;
	gate_t      g;

	assign f1 = (board1_state == B_FAULT);
	assign f2 = (board2_state == B_FAULT);

	// classify the request and work out the next mode
	always_comb begin
		desc.run = RUN_NONE;
		desc.status = ST_DONE;
		mode_n = mode_q;
		pending_n = pending_q;
		do_set = 1'b0;
		tgt = requested_mode;
		if (!cmd) begin
			do_set = 1'b0;
		end else begin
			priority if (requested_mode == M_INTERRUPT || requested_mode == M_TERMINATE) begin
				do_set = f1 && f2;
			end else if (f1 && f2) begin
				do_set = 1'b1;
				tgt = M_TERMINATE;
			end else if (f1) begin
				desc.run = RUN_FAULT_B2;
			end else if (f2) begin
				desc.run = RUN_FAULT_B1;
			end else if (board1_state == B_IDLE && board2_state == B_IDLE) begin
				do_set = 1'b1;
				tgt = M_IDLE;
			end else if (board1_state == B_DUMMY && board2_state == B_DUMMY) begin
				do_set = 1'b1;
				tgt = M_PRELIM;
			end else if (board1_state == B_DUMMY_END && board2_state == B_DUMMY_END) begin
				pending_n = 1'b1;
				desc.run = RUN_PREP_STATE;
			end else if (board1_state == B_PREPARE && board2_state == B_PREPARE) begin
				do_set = 1'b1;
				tgt = M_PREPARE;
			end else if (board1_state == B_READY && board2_state == B_READY) begin
				do_set = 1'b1;
				tgt = M_READY;
			end else if (board1_state == B_RADIATION && board2_state == B_RADIATION) begin
				do_set = 1'b1;
				tgt = M_WORK;
			end else if (board1_state == B_COMPLETE || board2_state == B_COMPLETE) begin
				do_set = 1'b1;
				tgt = M_COMPLETE;
			end else begin
				do_set = 1'b0;
			end
		end
		g = gate(tgt, mode_q, pending_q);
		if (!cmd) begin
			if (g.clr_pending) begin
				pending_n = 1'b0;
			end
			if (g.status != ST_DONE) begin
				desc.status = g.status;
			end else if (requested_mode == M_COMPLETE) begin
				desc.status = ST_INVALID;
			end else begin
				desc.run = remote_run(requested_mode);
			end
		end else if (do_set) begin
			if (g.clr_pending) begin
				pending_n = 1'b0;
			end
			desc.status = g.status;
			if (g.status == ST_DONE) begin
				mode_n = tgt;
			end
		end
		desc.mode = mode_n;
	end

	// supervisor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_INIT;
			pending_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_n;
			pending_q <= pending_n;
		end
	end

endmodule

// ===== hdl/dbms_queue.sv =====
module dbms_queue import dbms_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  desc_t wr_data,
	output logic  full,
	input  logic  rd_en,
	output logic  rd_valid,
	output desc_t rd_data
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	desc_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [PW:0]    count_q;

	assign full = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];

	// descriptor storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/dbms_back.sv =====
module dbms_back import dbms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        desc_valid,
	input  desc_t       desc,
	output logic        desc_pop,
	input  logic        pop,
	output logic        empty,
	output logic [3:0]  command_kind,
	output logic [1:0]  command_target,
	output logic [31:0] command_value,
	output logic [1:0]  status,
	output logic [3:0]  current_mode,
	output logic        last
);

	logic [3:0]  step_q;
	logic        out_valid_q;
	kind_t       kind_q;
	logic [1:0]  target_q;
	logic [31:0] value_q;
	logic [1:0]  status_q;
	logic [3:0]  mode_q;
	logic        last_q;
	logic        adv;
	cmd_t        c;

	// next command of the current run
	assign c = step_cmd(desc.run, step_q, cfg);
	assign adv = desc_valid && (!out_valid_q || pop);
	assign desc_pop = adv && c.last;

	// step counter and result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				step_q <= c.last ? '0 : step_q + 1'b1;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_q <= c.kind;
			target_q <= c.target;
			value_q <= c.value;
			status_q <= desc.status;
			mode_q <= desc.mode;
			last_q <= c.last;
		end
	end

	assign empty = !out_valid_q;
	assign command_kind = kind_q;
	assign command_target = target_q;
	assign command_value = value_q;
	assign status = status_q;
	assign current_mode = mode_q;
	assign last = last_q;

endmodule

// ===== hdl/dual_board_mode_supervisor.sv =====
// an accepted request passes through the descriptor queue and the result
// register before its first result shows
// the back sequencer gives one result per cycle while pop takes them or the
// result register is empty; a request has 1 to 12 results, and requests
// enter back to back while the two-entry descriptor queue has room
// reset: arst_n clears mode to init, the pending-prepare flag, the queue,
// the result valid flag and all configuration registers to zero
module dual_board_mode_supervisor import dbms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        cmd,
	input  logic [3:0]  requested_mode,
	input  logic [3:0]  board1_state,
	input  logic [3:0]  board2_state,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  command_kind,
	output logic [1:0]  command_target,
	output logic [31:0] command_value,
	output logic [1:0]  status,
	output logic [3:0]  current_mode,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t  cfg_q;
	desc_t front_desc;
	desc_t q_desc;
	logic  accept;
	logic  q_valid;
	logic  q_pop;

	assign accept = push && !full;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DUMMY_METER: cfg_q.dummy_meter <= cfg_data;
				CFG_PULSE_MODE:  cfg_q.pulse_cfg <= cfg_data[7:0];
				CFG_CAL_MODE:    cfg_q.cal_mode <= cfg_data[0];
				CFG_CAL_PRF:     cfg_q.cal_prf <= cfg_data;
				CFG_DOSE_METER:  cfg_q.cal_meter <= cfg_data;
				CFG_BEAM_ID:     cfg_q.beam_id <= cfg_data[15:0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	dbms_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.cmd            (cmd),
		.requested_mode (requested_mode),
		.board1_state   (board1_state),
		.board2_state   (board2_state),
		.desc           (front_desc)
	);

	dbms_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_data  (front_desc),
		.full     (full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_data  (q_desc)
	);

	dbms_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.desc_valid     (q_valid),
		.desc           (q_desc),
		.desc_pop       (q_pop),
		.pop            (pop),
		.empty          (empty),
		.command_kind   (command_kind),
		.command_target (command_target),
		.command_value  (command_value),
		.status         (status),
		.current_mode   (current_mode),
		.last           (last)
	);

endmodule

// ===== hdl/dbms_checker.sv =====
module dbms_checker import dbms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        empty,
	input  logic        pop,
	input  logic [3:0]  command_kind,
	input  logic [31:0] command_value,
	input  logic [1:0]  status,
	input  logic [3:0]  current_mode,
	input  logic        last
);

	// the queue fills only from requests
	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		!full && !push |=> !full)
		else $error("full rose without a request");

	// a run continues with the same status and mode
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !last |=> !empty && status == $past(status)
			&& current_mode == $past(current_mode))
		else $error("run broken before its last result");

	// a refused request gives a lone empty command
	a_refused_single: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status != ST_DONE |-> command_kind == K_NONE && last)
		else $error("refused request carried commands");

	// a stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(command_value) && $stable(last))
		else $error("stalled result changed");

endmodule

bind dual_board_mode_supervisor dbms_checker u_dbms_checker (.*);

// ===== tb/supervisor_check.sv =====
`timescale 1ns / 100ps

// request kinds on the cmd input, shared by the checker and the stimulus
package supervisor_tb_pkg;
	localparam logic REQ_REMOTE = 1'b0;
	localparam logic REQ_LOCAL  = 1'b1;
endpackage

module supervisor_check import dbms_pkg::*, supervisor_tb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        cmd,
	input  logic [3:0]  requested_mode,
	input  logic [3:0]  board1_state,
	input  logic [3:0]  board2_state,
	input  logic        empty,
	input  logic        pop,
	input  logic [3:0]  command_kind,
	input  logic [1:0]  command_target,
	input  logic [31:0] command_value,
	input  logic [1:0]  status,
	input  logic [3:0]  current_mode,
	input  logic        last,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          mismatches,
	output int          results_due
);

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  target;
		logic [31:0] value;
		logic [1:0]  status;
		logic [3:0]  mode;
		logic        last;
	} board_cmd_t;

	// supervisor state as the block should hold it
	logic [3:0] sup_mode = M_INIT;
	logic       prep_armed = 1'b0;

	// configuration copies
	logic [31:0] prelim_meter = '0;
	logic [7:0]  pulse_sel = '0;
	logic        cal_on = 1'b0;
	logic [31:0] cal_rate = '0;
	logic [31:0] cal_meter = '0;
	logic [15:0] beam_sel = '0;

	board_cmd_t run_q[$];
	board_cmd_t board_cmds_due[$];
	board_cmd_t want;
	int         bad_count = 0;
	int         results_seen = 0;

	assign mismatches = bad_count;
	assign results_due = board_cmds_due.size();

	task automatic note_mismatch(input string what);
		$display("mismatch at result %0d: %s", results_seen, what);
		bad_count++;
	endtask

	// mode transition table, written as the set of modes each mode can be entered from
	function automatic bit may_enter(input logic [3:0] from, input logic [3:0] to);
		bit ok;
		case (to)
			M_INIT:       ok = (from == M_IDLE);
			M_IDLE:       ok = (from == M_INIT) || (from == M_POWERSAVER) ||
					(from == M_TERMINATE) || (from == M_COMPLETE) ||
					(from == M_MANUAL) || (from == M_PARK);
			M_PRELIM:     ok = (from == M_IDLE);
			M_PREPARE:    ok = (from == M_PRELIM) || (from == M_COMPLETE);
			M_READY:      ok = (from == M_PREPARE) || (from == M_INTERRUPT);
			M_WORK:       ok = (from == M_READY);
			M_PARK:       ok = (from == M_IDLE);
			M_MANUAL:     ok = (from == M_IDLE);
			M_COMPLETE:   ok = (from == M_WORK);
			M_SHUTDOWN:   ok = (from == M_IDLE) || (from == M_POWERSAVER);
			M_POWERSAVER: ok = (from == M_IDLE);
			M_TERMINATE:  ok = (from == M_PRELIM) || (from == M_PREPARE) ||
					(from == M_READY) || (from == M_WORK) || (from == M_INTERRUPT);
			M_INTERRUPT:  ok = (from == M_READY) || (from == M_WORK);
			default:      ok = 1'b0;
		endcase
		return ok;
	endfunction

	// admission of a mode request; a pending prepare lets prepare-in-prepare through
	function automatic logic [1:0] admit(input logic [3:0] req);
		if (req >= M_COUNT)
			return ST_INVALID;
		if (req == sup_mode) begin
			if (prep_armed && req == M_PREPARE) begin
				prep_armed = 1'b0;
				return ST_DONE;
			end
			return ST_SAME;
		end
		return may_enter(sup_mode, req) ? ST_DONE : ST_ILLEGAL;
	endfunction

	function automatic void add_cmd(input kind_t k, input logic [1:0] tgt,
			input logic [31:0] val);
		board_cmd_t c;
		c = '0;
		c.kind = k;
		c.target = tgt;
		c.value = val;
		if (run_q.size() < 12)
			run_q.push_back(c);
	endfunction

	function automatic void add_both(input kind_t k, input logic [31:0] val);
		add_cmd(k, TGT_B1, val);
		add_cmd(k, TGT_B2, val);
	endfunction

	// board commands for an admitted remote request
	function automatic logic [1:0] issue_remote(input logic [3:0] req);
		case (req)
			M_INIT: begin
				add_cmd(K_HANDSHAKE, TGT_ALIGN, '0);
				add_cmd(K_HANDSHAKE, TGT_B1, '0);
				add_cmd(K_HANDSHAKE, TGT_B2, '0);
			end
			M_PRELIM: begin
				add_both(K_CLEAR, '0);
				add_both(K_GENMODE, '0);
				add_both(K_PULSE, '0);
				add_both(K_METER, prelim_meter);
				add_both(K_STATE, 32'(B_DUMMY));
			end
			M_PREPARE: begin
				add_both(K_CLEAR, '0);
				add_both(K_GENMODE, 32'd1);
				add_both(K_PULSE, 32'(pulse_sel));
				if (cal_on) begin
					add_both(K_PRF, cal_rate);
					add_both(K_METER, cal_meter);
				end else begin
					add_both(K_BEAM, 32'(beam_sel));
				end
				add_both(K_STATE, 32'(B_PREPARE));
			end
			M_READY:     add_both(K_STATE, 32'(B_READY));
			M_WORK:      add_both(K_STATE, 32'(B_RADIATION));
			M_COMPLETE:  return ST_INVALID;
			M_TERMINATE: add_both(K_STATE, 32'(B_FAULT));
			M_INTERRUPT: add_both(K_STATE, 32'(B_FAULT));
			default: ;
		endcase
		return ST_DONE;
	endfunction

	function automatic logic [1:0] move_to(input logic [3:0] target);
		logic [1:0] st;
		st = admit(target);
		if (st == ST_DONE)
			sup_mode = target;
		return st;
	endfunction

	// local poll: board state pairs drive the mode
	function automatic logic [1:0] poll_boards(input logic [3:0] req,
			input logic [3:0] b1, input logic [3:0] b2);
		bit f1;
		bit f2;
		f1 = (b1 == B_FAULT);
		f2 = (b2 == B_FAULT);
		if (req == M_INTERRUPT || req == M_TERMINATE)
			return (f1 && f2) ? move_to(req) : ST_DONE;
		if (f1 && f2)
			return move_to(M_TERMINATE);
		if (f1 || f2) begin
			// push the healthy partner into fault as well
			if (f1)
				add_cmd(K_STATE, TGT_B2, 32'(B_FAULT));
			if (f2)
				add_cmd(K_STATE, TGT_B1, 32'(B_FAULT));
			return ST_DONE;
		end
		if (b1 == B_IDLE && b2 == B_IDLE)
			return move_to(M_IDLE);
		if (b1 == B_DUMMY && b2 == B_DUMMY)
			return move_to(M_PRELIM);
		if (b1 == B_DUMMY_END && b2 == B_DUMMY_END) begin
			prep_armed = 1'b1;
			add_both(K_STATE, 32'(B_PREPARE));
			return ST_DONE;
		end
		if (b1 == B_PREPARE && b2 == B_PREPARE)
			return move_to(M_PREPARE);
		if (b1 == B_READY && b2 == B_READY)
			return move_to(M_READY);
		if (b1 == B_RADIATION && b2 == B_RADIATION)
			return move_to(M_WORK);
		if (b1 == B_COMPLETE || b2 == B_COMPLETE)
			return move_to(M_COMPLETE);
		return ST_DONE;
	endfunction

	// expected command run for one accepted request
	task automatic predict_item(input logic c, input logic [3:0] req,
			input logic [3:0] b1, input logic [3:0] b2);
		logic [1:0] st;
		board_cmd_t e;
		run_q.delete();
		if (c == REQ_REMOTE) begin
			st = admit(req);
			if (st == ST_DONE)
				st = issue_remote(req);
		end else begin
			st = poll_boards(req, b1, b2);
		end
		if (st != ST_DONE)
			run_q.delete();
		if (run_q.size() == 0)
			add_cmd(K_NONE, TGT_ALIGN, '0);
		foreach (run_q[i]) begin
			e = run_q[i];
			e.status = st;
			e.mode = sup_mode;
			e.last = (i == run_q.size() - 1);
			board_cmds_due.push_back(e);
		end
	endtask

	// watch all three channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (board_cmds_due.size() == 0) begin
					note_mismatch($sformatf("unexpected result kind %0d target %0d value %0h",
						command_kind, command_target, command_value));
				end else begin
					want = board_cmds_due.pop_front();
					if (command_kind != want.kind)
						note_mismatch($sformatf("kind %0d, expected %0d",
							command_kind, want.kind));
					if (command_target != want.target)
						note_mismatch($sformatf("target %0d, expected %0d",
							command_target, want.target));
					if (command_value != want.value)
						note_mismatch($sformatf("value %0h, expected %0h",
							command_value, want.value));
					if (status != want.status)
						note_mismatch($sformatf("status %0d, expected %0d",
							status, want.status));
					if (current_mode != want.mode)
						note_mismatch($sformatf("mode %0d, expected %0d",
							current_mode, want.mode));
					if (last != want.last)
						note_mismatch($sformatf("last %0d, expected %0d", last, want.last));
				end
				results_seen++;
			end
			if (push && !full)
				predict_item(cmd, requested_mode, board1_state, board2_state);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DUMMY_METER: prelim_meter = cfg_data;
					CFG_PULSE_MODE:  pulse_sel = cfg_data[7:0];
					CFG_CAL_MODE:    cal_on = cfg_data[0];
					CFG_CAL_PRF:     cal_rate = cfg_data;
					CFG_DOSE_METER:  cal_meter = cfg_data;
					CFG_BEAM_ID:     beam_sel = cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb import dbms_pkg::*, supervisor_tb_pkg::*;;

	localparam int RANDOM_ITEMS = 180;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        cmd = 1'b0;
	logic [3:0]  requested_mode = '0;
	logic [3:0]  board1_state = '0;
	logic [3:0]  board2_state = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [3:0]  command_kind;
	logic [1:0]  command_target;
	logic [31:0] command_value;
	logic [1:0]  status;
	logic [3:0]  current_mode;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	int          mismatches;
	int          results_due;
	int          items_sent = 0;
	int unsigned cycle_count = 0;
	bit          steady = 1'b0;

	dual_board_mode_supervisor DUT (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.cmd(cmd), .requested_mode(requested_mode),
		.board1_state(board1_state), .board2_state(board2_state),
		.empty(empty), .pop(pop),
		.command_kind(command_kind), .command_target(command_target),
		.command_value(command_value), .status(status),
		.current_mode(current_mode), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	supervisor_check u_check (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.cmd(cmd), .requested_mode(requested_mode),
		.board1_state(board1_state), .board2_state(board2_state),
		.empty(empty), .pop(pop),
		.command_kind(command_kind), .command_target(command_target),
		.command_value(command_value), .status(status),
		.current_mode(current_mode), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .results_due(results_due)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side stalls at random, except during the steady stretch
	initial begin
		forever begin
			@(posedge clk);
			pop <= steady || ($urandom_range(99) >= 26);
		end
	end

	function automatic logic [3:0] any_nibble();
		return 4'($urandom_range(15));
	endfunction

	// stored request for a local poll that stays off the interrupt/terminate branch
	function automatic logic [3:0] quiet_req();
		return 4'($urandom_range(10));
	endfunction

	task automatic send_item(input logic c, input logic [3:0] req,
			input logic [3:0] s1, input logic [3:0] s2);
		while (!steady && $urandom_range(99) < 26) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		cmd <= c;
		requested_mode <= req;
		board1_state <= s1;
		board2_state <= s2;
		do @(posedge clk); while (full);
		items_sent++;
	endtask

	// occasional fully random request between well-formed steps
	task automatic stray_item();
		if ($urandom_range(99) < 30)
			send_item(logic'($urandom_range(1)), any_nibble(), any_nibble(), any_nibble());
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// block goes quiet once every expected result has been popped
	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
	endtask

	task automatic load_settings(input logic [31:0] pre_meter, input logic [7:0] pmode,
			input logic cal, input logic [31:0] prf, input logic [31:0] meter,
			input logic [15:0] beam);
		wait_drained();
		write_reg(CFG_DUMMY_METER, pre_meter);
		write_reg(CFG_PULSE_MODE, 32'(pmode));
		write_reg(CFG_CAL_MODE, 32'(cal));
		write_reg(CFG_CAL_PRF, prf);
		write_reg(CFG_DOSE_METER, meter);
		write_reg(CFG_BEAM_ID, 32'(beam));
		cfg_valid <= 1'b0;
	endtask

	// one pass through the board life: recover to idle, dummy run, prepare, work, exit
	task automatic run_lifecycle();
		int ending;
		logic [3:0] other;
		ending = $urandom_range(3);
		other = 4'($urandom_range(6));
		stray_item();
		send_item(REQ_LOCAL, quiet_req(), B_FAULT, B_FAULT);
		stray_item();
		send_item(REQ_LOCAL, quiet_req(), B_IDLE, B_IDLE);
		send_item(REQ_REMOTE, M_PRELIM, any_nibble(), any_nibble());
		stray_item();
		send_item(REQ_LOCAL, quiet_req(), B_DUMMY, B_DUMMY);
		send_item(REQ_LOCAL, quiet_req(), B_DUMMY_END, B_DUMMY_END);
		stray_item();
		send_item(REQ_LOCAL, quiet_req(), B_PREPARE, B_PREPARE);
		send_item(REQ_REMOTE, M_PREPARE, any_nibble(), any_nibble());
		send_item(REQ_LOCAL, quiet_req(), B_READY, B_READY);
		stray_item();
		send_item(REQ_REMOTE, M_WORK, any_nibble(), any_nibble());
		send_item(REQ_LOCAL, quiet_req(), B_RADIATION, B_RADIATION);
		case (ending)
			0: begin
				if ($urandom_range(1))
					send_item(REQ_LOCAL, quiet_req(), B_COMPLETE, other);
				else
					send_item(REQ_LOCAL, quiet_req(), other, B_COMPLETE);
			end
			1: send_item(REQ_LOCAL, M_INTERRUPT, B_FAULT, B_FAULT);
			2: send_item(REQ_REMOTE, $urandom_range(1) ? M_TERMINATE : M_INTERRUPT,
				any_nibble(), any_nibble());
			default: begin
				send_item(REQ_LOCAL, quiet_req(), B_FAULT, other);
				send_item(REQ_LOCAL, M_TERMINATE, B_FAULT, B_FAULT);
			end
		endcase
		stray_item();
	endtask

	initial begin
		int cycles_done;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// top values, calibration on
		load_settings('1, 8'hFF, 1'b1, '1, '1, 16'hFFFF);

		// directed: gate outcomes, every command run except the ready run, board fault handling
		send_item(REQ_REMOTE, 4'hF, B_IDLE, B_IDLE);
		send_item(REQ_REMOTE, M_INIT, B_IDLE, B_IDLE);
		send_item(REQ_REMOTE, M_READY, B_IDLE, B_IDLE);
		send_item(REQ_LOCAL, M_INIT, B_IDLE, B_IDLE);
		send_item(REQ_REMOTE, M_INIT, B_IDLE, B_IDLE);
		send_item(REQ_REMOTE, M_COMPLETE, B_IDLE, B_IDLE);
		send_item(REQ_REMOTE, M_PRELIM, B_IDLE, B_IDLE);
		send_item(REQ_LOCAL, M_PRELIM, B_DUMMY, B_DUMMY);
		send_item(REQ_LOCAL, M_PRELIM, B_DUMMY_END, B_DUMMY_END);
		send_item(REQ_LOCAL, M_PREPARE, B_PREPARE, B_PREPARE);
		send_item(REQ_REMOTE, M_PREPARE, B_PREPARE, B_PREPARE);
		send_item(REQ_LOCAL, M_PREPARE, B_PREPARE, B_PREPARE);
		send_item(REQ_LOCAL, M_PREPARE, B_DUMMY_END, B_DUMMY_END);
		send_item(REQ_LOCAL, M_PREPARE, B_PREPARE, B_PREPARE);
		send_item(REQ_LOCAL, M_READY, B_READY, B_READY);
		send_item(REQ_REMOTE, M_INTERRUPT, B_READY, B_READY);
		send_item(REQ_REMOTE, M_WORK, B_READY, B_READY);
		send_item(REQ_LOCAL, M_WORK, B_RADIATION, B_RADIATION);
		send_item(REQ_REMOTE, M_COMPLETE, B_RADIATION, B_RADIATION);
		send_item(REQ_LOCAL, M_WORK, B_FAULT, B_IDLE);
		send_item(REQ_LOCAL, M_WORK, B_IDLE, B_FAULT);
		send_item(REQ_LOCAL, M_INTERRUPT, B_FAULT, B_FAULT);
		send_item(REQ_LOCAL, M_IDLE, B_FAULT, B_FAULT);
		send_item(REQ_LOCAL, M_TERMINATE, B_FAULT, B_FAULT);
		send_item(REQ_LOCAL, M_IDLE, B_IDLE, B_IDLE);
		send_item(REQ_LOCAL, M_IDLE, B_COMPLETE, B_PREPARE);
		send_item(REQ_LOCAL, M_IDLE, 4'd8, 4'hF);
		send_item(REQ_REMOTE, M_SHUTDOWN, B_IDLE, B_IDLE);

		// all zero, calibration off
		load_settings('0, 8'h00, 1'b0, '0, '0, 16'h0000);

		// random part: board lifecycles with noise, settings changed now and then
		cycles_done = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (cycles_done % 3 == 2)
				load_settings($urandom, 8'($urandom_range(255)), logic'($urandom_range(1)),
					$urandom, $urandom, 16'($urandom_range(65535)));
			steady = (cycles_done == 4 || cycles_done == 5);
			run_lifecycle();
			cycles_done++;
		end
		steady = 1'b0;

		wait_drained();
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
